// ===== design/tctpc_pkg.sv =====
// Package for the two-class topological phase counter.
// Holds the port widths, command and register codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tctpc_pkg;

    localparam int NODE_FW     = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int PHASE_W     = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    localparam logic REG_CLASS_A = 1'b0;
    localparam logic REG_CLASS_B = 1'b1;

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_CLR     = 21'h000002,
        S_CNT_RD  = 21'h000004,
        S_CNT_MOD = 21'h000008,
        S_CNT_WR  = 21'h000010,
        S_PFX_RD  = 21'h000020,
        S_PFX_WR  = 21'h000040,
        S_FIL_RD  = 21'h000080,
        S_FIL_MOD = 21'h000100,
        S_FIL_WR  = 21'h000200,
        S_INI_RD  = 21'h000400,
        S_INI_WR  = 21'h000800,
        S_CHK     = 21'h001000,
        S_POP     = 21'h002000,
        S_ADJ_RD  = 21'h004000,
        S_ADJ_LD  = 21'h008000,
        S_EDG     = 21'h010000,
        S_EDG_RD  = 21'h020000,
        S_EDG_WR  = 21'h040000,
        S_FIN     = 21'h080000,
        S_OUT     = 21'h100000
    } state_t;

endpackage

`default_nettype wire

// ===== design/two_class_topo_phase_count_unit.sv =====
// Top level of the two-class topological phase counter: edge store, CSR build,
// two Kahn sort runs over block memories and the result register.
// Depends on tctpc_pkg.
//
// channel  | direction | transfer when            | payload
// s_axis   | in        | s_axis_tvalid & tready   | tuser: cmd; tdata: dependent, prerequisite
// m_axis   | out       | m_axis_tvalid & tready   | tdata: phase_count, status
// cfg      | in        | cfg_valid & cfg_ready    | cfg_index, cfg_data
//
// A load item is taken whenever the unit is idle. A solve item runs the
// single-port read/modify/write steps over the node and edge memories, and
// s_axis_tready stays low until its result is in the output register.
// Reset clears control state only; every memory entry is written before it is read.
// A finished result waits in the output register while loads are still taken;
// a second solve holds its result until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module two_class_topo_phase_count_unit #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [10:0] dependent_node, [21:11] prerequisite_node, [23:22] zero
    input  wire logic [tctpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] cmd
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [10:0] phase_count, [11] status, [15:12] zero
    output logic [tctpc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_index,
    input  wire logic [tctpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import tctpc_pkg::*;

    localparam int NW     = $clog2(MAX_NODES);
    localparam int EW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DW     = EW + 1;
    localparam int IW     = ((NW > EW) ? NW : EW) + 1;
    localparam int SW     = (NW + 1 > 12) ? NW + 1 : 12;
    localparam int CW     = NW + 2;
    localparam int EDGE_W = 2 * NW;

    state_t               state_reg, state_next;
    logic [CFG_DATA_W-1:0] cls_a_reg, cls_b_reg;
    logic [DW-1:0]        edge_total_reg, edge_total_next;
    logic                 dropped_reg, dropped_next;
    logic [SW-1:0]        total_reg, total_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [DW-1:0]        sum_reg, sum_next;
    logic                 cur_reg, cur_next;
    logic                 run_reg, run_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        ca_reg, ca_next;
    logic [NW:0]          head_a_reg, head_a_next, tail_a_reg, tail_a_next;
    logic [NW:0]          head_b_reg, head_b_next, tail_b_reg, tail_b_next;
    logic [DW-1:0]        k_reg, k_next, end_reg, end_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PHASE_W-1:0]   out_count_reg, out_count_next;
    logic                 out_status_reg, out_status_next;

    logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
    logic [DW-1:0]     indeg_mem [MAX_NODES];
    logic [DW-1:0]     fill_mem [MAX_NODES];
    logic [2*DW-1:0]   adj_mem [MAX_NODES];
    logic [NW-1:0]     list_mem [MAX_EDGES];
    logic [DW-1:0]     work_mem [MAX_NODES];
    logic [NW-1:0]     qa_mem [MAX_NODES];
    logic [NW-1:0]     qb_mem [MAX_NODES];

    logic [EDGE_W-1:0] edge_q;
    logic [DW-1:0]     indeg_q, fill_q, work_q;
    logic [2*DW-1:0]   adj_q;
    logic [NW-1:0]     list_q, qa_q, qb_q;

    logic              e_we, e_re;
    logic [EW-1:0]     e_wa, e_ra;
    logic [EDGE_W-1:0] e_wd;
    logic              d_we, d_re;
    logic [NW-1:0]     d_wa, d_ra;
    logic [DW-1:0]     d_wd;
    logic              f_we, f_re;
    logic [NW-1:0]     f_wa, f_ra;
    logic [DW-1:0]     f_wd;
    logic              a_we, a_re;
    logic [NW-1:0]     a_wa, a_ra;
    logic [2*DW-1:0]   a_wd;
    logic              l_we, l_re;
    logic [EW-1:0]     l_wa, l_ra;
    logic [NW-1:0]     l_wd;
    logic              w_we, w_re;
    logic [NW-1:0]     w_wa, w_ra;
    logic [DW-1:0]     w_wd;
    logic              qa_we, qb_we, qa_re, qb_re;

    logic              push_en;
    logic [NW-1:0]     push_node;

    logic [NODE_FW-1:0] in_dep, in_pre;
    logic [SW-1:0]      sum_w, total_now;
    logic               load_bad;
    logic [NW-1:0]      edge_dep, edge_pre, pop_node;
    logic               edge_ok, cur_nonempty;
    logic [DW-1:0]      work_dec;
    logic [CW-1:0]      best;

    assign in_dep    = s_axis_tdata[NODE_FW-1:0];
    assign in_pre    = s_axis_tdata[2*NODE_FW-1:NODE_FW];
    assign sum_w     = SW'(cls_a_reg) + SW'(cls_b_reg);
    assign total_now = (sum_w > SW'(MAX_NODES)) ? SW'(MAX_NODES) : sum_w;
    assign load_bad  = (in_dep == '0) || (in_pre == '0) || (SW'(in_dep) > total_now)
                       || (SW'(in_pre) > total_now) || (edge_total_reg == DW'(MAX_EDGES));

    assign edge_dep = edge_q[EDGE_W-1:NW];
    assign edge_pre = edge_q[NW-1:0];
    assign edge_ok  = (SW'(edge_dep) < total_reg) && (SW'(edge_pre) < total_reg);
    assign pop_node = cur_reg ? qb_q : qa_q;
    assign cur_nonempty = cur_reg ? (head_b_reg != tail_b_reg) : (head_a_reg != tail_a_reg);
    assign work_dec = (work_q != '0) ? (work_q - DW'(1)) : work_q;
    assign best     = (ca_reg < count_reg) ? ca_reg : count_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_status_reg, out_count_reg};

    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        dropped_next    = dropped_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        cur_next        = cur_reg;
        run_next        = run_reg;
        count_next      = count_reg;
        ca_next         = ca_reg;
        head_a_next     = head_a_reg;
        head_b_next     = head_b_reg;
        tail_a_next     = tail_a_reg;
        tail_b_next     = tail_b_reg;
        k_next          = k_reg;
        end_next        = end_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        e_we = 1'b0; e_re = 1'b0; e_wa = '0; e_ra = idx_reg[EW-1:0];
        e_wd = {NW'(in_dep - NODE_FW'(1)), NW'(in_pre - NODE_FW'(1))};
        d_we = 1'b0; d_re = 1'b0; d_wa = '0; d_ra = '0; d_wd = '0;
        f_we = 1'b0; f_re = 1'b0; f_wa = '0; f_ra = '0; f_wd = '0;
        a_we = 1'b0; a_re = 1'b0; a_wa = idx_reg[NW-1:0]; a_ra = pop_node;
        a_wd = {DW'(sum_reg + fill_q), sum_reg};
        l_we = 1'b0; l_re = 1'b0; l_wa = fill_q[EW-1:0]; l_ra = k_reg[EW-1:0];
        l_wd = edge_dep;
        w_we = 1'b0; w_re = 1'b0; w_wa = '0; w_ra = list_q; w_wd = '0;
        qa_re = 1'b0; qb_re = 1'b0;
        push_en = 1'b0; push_node = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == CMD_SOLVE)
                    begin
                        total_next = total_now;
                        idx_next   = '0;
                        state_next = S_CLR;
                    end
                    else if (load_bad)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        e_we            = 1'b1;
                        e_wa            = edge_total_reg[EW-1:0];
                        edge_total_next = edge_total_reg + DW'(1);
                    end
                end
            end
            S_CLR:
            begin
                d_we = 1'b1; d_wa = idx_reg[NW-1:0];
                f_we = 1'b1; f_wa = idx_reg[NW-1:0];
                if (idx_reg == IW'(MAX_NODES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_CNT_RD;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_CNT_RD:
            begin
                if (idx_reg == IW'(edge_total_reg))
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_PFX_RD;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = S_CNT_MOD;
                end
            end
            S_CNT_MOD:
            begin
                if (edge_ok)
                begin
                    d_re = 1'b1; d_ra = edge_dep;
                    f_re = 1'b1; f_ra = edge_pre;
                    state_next = S_CNT_WR;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_WR:
            begin
                d_we = 1'b1; d_wa = edge_dep; d_wd = indeg_q + DW'(1);
                f_we = 1'b1; f_wa = edge_pre; f_wd = fill_q + DW'(1);
                idx_next   = idx_reg + IW'(1);
                state_next = S_CNT_RD;
            end
            S_PFX_RD:
            begin
                f_re = 1'b1; f_ra = idx_reg[NW-1:0];
                state_next = S_PFX_WR;
            end
            S_PFX_WR:
            begin
                f_we = 1'b1; f_wa = idx_reg[NW-1:0]; f_wd = sum_reg;
                a_we = 1'b1;
                sum_next = DW'(sum_reg + fill_q);
                if (idx_reg == IW'(MAX_NODES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_FIL_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_PFX_RD;
                end
            end
            S_FIL_RD:
            begin
                if (idx_reg == IW'(edge_total_reg))
                begin
                    idx_next    = '0;
                    run_next    = 1'b0;
                    cur_next    = 1'b0;
                    count_next  = CW'(1);
                    head_a_next = '0; tail_a_next = '0;
                    head_b_next = '0; tail_b_next = '0;
                    state_next  = S_INI_RD;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = S_FIL_MOD;
                end
            end
            S_FIL_MOD:
            begin
                if (edge_ok)
                begin
                    f_re = 1'b1; f_ra = edge_pre;
                    state_next = S_FIL_WR;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_FIL_RD;
                end
            end
            S_FIL_WR:
            begin
                l_we = 1'b1;
                f_we = 1'b1; f_wa = edge_pre; f_wd = fill_q + DW'(1);
                idx_next   = idx_reg + IW'(1);
                state_next = S_FIL_RD;
            end
            S_INI_RD:
            begin
                d_re = 1'b1; d_ra = idx_reg[NW-1:0];
                state_next = S_INI_WR;
            end
            S_INI_WR:
            begin
                w_we = 1'b1; w_wa = idx_reg[NW-1:0]; w_wd = indeg_q;
                if ((SW'(idx_reg[NW-1:0]) < total_reg) && (indeg_q == '0))
                begin
                    push_en   = 1'b1;
                    push_node = idx_reg[NW-1:0];
                end
                if (idx_reg == IW'(MAX_NODES - 1))
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_INI_RD;
                end
            end
            S_CHK:
            begin
                if ((head_a_reg == tail_a_reg) && (head_b_reg == tail_b_reg))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (cur_nonempty)
                begin
                    if (cur_reg)
                    begin
                        qb_re       = 1'b1;
                        head_b_next = head_b_reg + (NW+1)'(1);
                    end
                    else
                    begin
                        qa_re       = 1'b1;
                        head_a_next = head_a_reg + (NW+1)'(1);
                    end
                    state_next = S_ADJ_RD;
                end
                else
                begin
                    cur_next   = !cur_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_CHK;
                end
            end
            S_ADJ_RD:
            begin
                a_re       = 1'b1;
                state_next = S_ADJ_LD;
            end
            S_ADJ_LD:
            begin
                k_next     = adj_q[DW-1:0];
                end_next   = adj_q[2*DW-1:DW];
                state_next = S_EDG;
            end
            S_EDG:
            begin
                if (k_reg == end_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    l_re       = 1'b1;
                    state_next = S_EDG_RD;
                end
            end
            S_EDG_RD:
            begin
                w_re       = 1'b1;
                state_next = S_EDG_WR;
            end
            S_EDG_WR:
            begin
                w_we = 1'b1; w_wa = list_q; w_wd = work_dec;
                if (work_dec == '0)
                begin
                    push_en   = 1'b1;
                    push_node = list_q;
                end
                k_next     = k_reg + DW'(1);
                state_next = S_EDG;
            end
            S_FIN:
            begin
                if (!run_reg)
                begin
                    ca_next     = count_reg;
                    run_next    = 1'b1;
                    cur_next    = 1'b1;
                    count_next  = CW'(1);
                    idx_next    = '0;
                    head_a_next = '0; tail_a_next = '0;
                    head_b_next = '0; tail_b_next = '0;
                    state_next  = S_INI_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = PHASE_W'(best);
                    out_status_next = dropped_reg;
                    edge_total_next = '0;
                    dropped_next    = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        qa_we = push_en && (SW'(push_node) < SW'(cls_a_reg));
        qb_we = push_en && !(SW'(push_node) < SW'(cls_a_reg));
        if (qa_we)
        begin
            tail_a_next = tail_a_reg + (NW+1)'(1);
        end
        if (qb_we)
        begin
            tail_b_next = tail_b_reg + (NW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cls_a_reg      <= '0;
            cls_b_reg      <= '0;
            edge_total_reg <= '0;
            dropped_reg    <= 1'b0;
            total_reg      <= '0;
            idx_reg        <= '0;
            sum_reg        <= '0;
            cur_reg        <= 1'b0;
            run_reg        <= 1'b0;
            count_reg      <= '0;
            ca_reg         <= '0;
            head_a_reg     <= '0;
            head_b_reg     <= '0;
            tail_a_reg     <= '0;
            tail_b_reg     <= '0;
            k_reg          <= '0;
            end_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            dropped_reg    <= dropped_next;
            total_reg      <= total_next;
            idx_reg        <= idx_next;
            sum_reg        <= sum_next;
            cur_reg        <= cur_next;
            run_reg        <= run_next;
            count_reg      <= count_next;
            ca_reg         <= ca_next;
            head_a_reg     <= head_a_next;
            head_b_reg     <= head_b_next;
            tail_a_reg     <= tail_a_next;
            tail_b_reg     <= tail_b_next;
            k_reg          <= k_next;
            end_reg        <= end_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CLASS_A)
                begin
                    cls_a_reg <= cfg_data;
                end
                else
                begin
                    cls_b_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_wa] <= e_wd;
        end
        if (e_re)
        begin
            edge_q <= edge_mem[e_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            indeg_mem[d_wa] <= d_wd;
        end
        if (d_re)
        begin
            indeg_q <= indeg_mem[d_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fill_mem[f_wa] <= f_wd;
        end
        if (f_re)
        begin
            fill_q <= fill_mem[f_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            adj_mem[a_wa] <= a_wd;
        end
        if (a_re)
        begin
            adj_q <= adj_mem[a_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            list_mem[l_wa] <= l_wd;
        end
        if (l_re)
        begin
            list_q <= list_mem[l_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            work_mem[w_wa] <= w_wd;
        end
        if (w_re)
        begin
            work_q <= work_mem[w_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (qa_we)
        begin
            qa_mem[tail_a_reg[NW-1:0]] <= push_node;
        end
        if (qa_re)
        begin
            qa_q <= qa_mem[head_a_reg[NW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (qb_we)
        begin
            qb_mem[tail_b_reg[NW-1:0]] <= push_node;
        end
        if (qb_re)
        begin
            qb_q <= qb_mem[head_b_reg[NW-1:0]];
        end
    end

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (head_a_reg <= tail_a_reg) && (head_b_reg <= tail_b_reg))
        else $error("ready queue head passed its tail");

    a_release_once: assert property (@(posedge clk) disable iff (!rst_n)
        ((NW+2)'(tail_a_reg) + (NW+2)'(tail_b_reg)) <= (NW+2)'(MAX_NODES))
        else $error("more releases than nodes");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= DW'(MAX_EDGES))
        else $error("edge count beyond capacity");

    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PFX_RD) |-> (sum_reg <= edge_total_reg))
        else $error("adjacency prefix sum beyond stored edges");

    a_second_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && run_reg) |=> (state_reg == S_OUT))
        else $error("second sort run did not move to result");

endmodule

`default_nettype wire
